>>> sv/fccw_pkg.sv
// Shared types and constants for the FAT16 cluster chain walker.
package fccw_pkg;

  localparam int unsigned ClusterW = 16;
  localparam int unsigned IndexW   = 12;
  localparam int unsigned PosW     = 6;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

  localparam logic [ClusterW-1:0] LinkEndMin   = 16'hFFF8;
  localparam logic [ClusterW-1:0] LinkMinValid = 16'd2;

  localparam logic KindWrite = 1'b0;
  localparam logic KindWalk  = 1'b1;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StBadStart = 3'd1;
  localparam logic [StatusW-1:0] StSmallVol = 3'd2;
  localparam logic [StatusW-1:0] StOutside  = 3'd3;
  localparam logic [StatusW-1:0] StTrunc    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_OUT
  } walk_state_e;

endpackage

>>> sv/fat16_cluster_chain_walker.sv
// FAT16 cluster chain walker: table memory, walk sequencer and result register.
// A write transaction stores one link if its index lies inside the table. A walk
// transaction emits the start cluster and each following cluster until an end marker,
// a free or reserved link, a cluster beyond the table or the MAX_CHAIN limit; the final
// result carries tlast. Each result needs a table read and a result load, plus any wait
// on m_axis_tready, and the table memory has a single read port; a walk gives at most
// MAX_CHAIN results. Early failures (volume too small, bad start, start beyond the
// table) give one result in the cycle after the transaction. The input is not ready
// during a walk.
// Table entries must be written before a walk reads them.
module fat16_cluster_chain_walker #(
  parameter int unsigned FAT_ENTRIES = 4096,
  parameter int unsigned MAX_CHAIN   = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fccw_pkg::ClusterW-1:0]  cfg_data_i,     // usable_clusters
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // entry_index[11:0], entry_value[27:12], start_cluster[43:28], zero fill
  input  logic [fccw_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tuser,   // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // cluster[15:0], position[21:16], status[24:22], zero fill
  output logic [fccw_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast    // last
);
  import fccw_pkg::*;

  localparam int unsigned IdxW = (FAT_ENTRIES > 1) ? $clog2(FAT_ENTRIES) : 1;
  localparam logic [ClusterW:0] EntriesW = (ClusterW+1)'(FAT_ENTRIES);
  localparam logic [PosW-1:0]   LastPos  = PosW'(MAX_CHAIN - 1);

  walk_state_e state_q, state_d;

  logic [ClusterW-1:0] usable_q;
  logic [ClusterW-1:0] cur_q, cur_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [ClusterW-1:0] out_cluster_q, out_cluster_d;
  logic [PosW-1:0]     out_pos_q, out_pos_d;
  logic                out_last_q, out_last_d;
  logic [StatusW-1:0]  out_status_q, out_status_d;

  logic [ClusterW-1:0] mem [FAT_ENTRIES];
  logic [ClusterW-1:0] rd_q;
  logic [IdxW-1:0]     rd_addr;
  logic [IdxW-1:0]     wr_addr;
  logic                mem_we;

  logic                in_kind;
  logic [IndexW-1:0]   in_index;
  logic [ClusterW-1:0] in_value;
  logic [ClusterW-1:0] in_start;
  logic                in_fire;
  logic [ClusterW:0]   index_wide;
  logic                index_ok;
  logic                start_outside;
  logic                cur_outside;
  logic                walk_early;
  logic                link_end;
  logic                at_limit;

  assign in_kind  = s_axis_tuser;
  assign in_index = s_axis_tdata[11:0];
  assign in_value = s_axis_tdata[27:12];
  assign in_start = s_axis_tdata[43:28];
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  assign index_wide    = (ClusterW+1)'(in_index);
  assign index_ok      = index_wide < EntriesW;
  assign wr_addr       = index_wide[IdxW-1:0];
  assign start_outside = {1'b0, in_start} >= EntriesW;
  assign cur_outside   = {1'b0, cur_q} >= EntriesW;
  assign walk_early    = (usable_q < LinkMinValid) || (in_start < LinkMinValid)
                         || start_outside;
  assign link_end      = (rd_q >= LinkEndMin) || (rd_q < LinkMinValid);
  assign at_limit      = pos_q == LastPos;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && in_kind == KindWalk) begin
          state_d = walk_early ? S_OUT : S_LOOK;
        end
      end
      S_LOOK: state_d = S_OUT;
      S_OUT: begin
        if (m_axis_tready) begin
          if (out_last_q) begin
            state_d = S_IDLE;
          end else if (!cur_outside) begin
            state_d = S_LOOK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake outputs and table read address
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    rd_addr       = cur_q[IdxW-1:0];
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        rd_addr       = in_start[IdxW-1:0];
      end
      S_LOOK: ;
      S_OUT:  m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  // Walk datapath
  always_comb begin
    cur_d         = cur_q;
    pos_d         = pos_q;
    out_cluster_d = out_cluster_q;
    out_pos_d     = out_pos_q;
    out_last_d    = out_last_q;
    out_status_d  = out_status_q;
    mem_we        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_kind == KindWrite) begin
            mem_we = index_ok;
          end else begin
            cur_d         = in_start;
            pos_d         = '0;
            out_cluster_d = in_start;
            out_pos_d     = '0;
            out_last_d    = 1'b1;
            if (usable_q < LinkMinValid) begin
              out_status_d = StSmallVol;
            end else if (in_start < LinkMinValid) begin
              out_status_d = StBadStart;
            end else begin
              out_status_d = StOutside;
            end
          end
        end
      end
      S_LOOK: begin
        out_cluster_d = cur_q;
        out_pos_d     = pos_q;
        out_last_d    = link_end || at_limit;
        out_status_d  = (!link_end && at_limit) ? StTrunc : StOk;
        cur_d         = rd_q;
        pos_d         = pos_q + 1'b1;
      end
      S_OUT: begin
        // a link beyond the table ends the walk without a read
        if (m_axis_tready && !out_last_q && cur_outside) begin
          out_cluster_d = cur_q;
          out_pos_d     = pos_q;
          out_last_d    = 1'b1;
          out_status_d  = StOutside;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= in_value;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      usable_q <= 16'hFFFF;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        usable_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q         <= cur_d;
    pos_q         <= pos_d;
    out_cluster_q <= out_cluster_d;
    out_pos_q     <= out_pos_d;
    out_last_q    <= out_last_d;
    out_status_q  <= out_status_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {7'd0, out_status_q, out_pos_q, out_cluster_q};
  assign m_axis_tlast = out_last_q;

endmodule
